>>> sv/gbt_pkg.sv
// Shared constants for the graph traversal block.
`timescale 1ns / 1ps

package gbt_pkg;

  // Graph size limit (default of the top level parameter)
  localparam int MAX_VERTICES_DEF = 32;

  // Request fields
  localparam int CMD_W = 2;
  localparam int VTX_W = 5;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BFS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DFS = 2'd2;

  // Register file
  localparam int              VC_W     = 6;
  localparam logic [VC_W-1:0] VC_RESET = 6'd32;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Word index of each register (paddr[APB_AW-1])
  localparam logic REG_VERTEX_COUNT = 1'b0;

endpackage

>>> sv/gbt_in_if.sv
// Request channel: command and vertex operands with valid/ready.
`timescale 1ns / 1ps

interface gbt_in_if import gbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VTX_W-1:0] first_vertex;
  logic [VTX_W-1:0] second_vertex;

  modport source (output valid, output cmd, output first_vertex, output second_vertex,
                  input ready);
  modport sink   (input valid, input cmd, input first_vertex, input second_vertex,
                  output ready);
endinterface

>>> sv/gbt_out_if.sv
// Result channel: visited vertex and end-of-traversal flag with valid/ready.
`timescale 1ns / 1ps

interface gbt_out_if import gbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] visited_vertex;
  logic             last;

  modport source (output valid, output visited_vertex, output last, input ready);
  modport sink   (input valid, input visited_vertex, input last, output ready);
endinterface

>>> sv/gbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gbt_ram import gbt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/graph_bfs_dfs_traversal.sv
// Graph traversal block: adjacency bit matrix with breadth- and depth-first walks.
`timescale 1ns / 1ps
// Usage
//   Requests arrive on in_ch (valid/ready). cmd 0 adds an undirected edge
//   between first_vertex and second_vertex and returns nothing. cmd 1 walks
//   the graph breadth-first and cmd 2 depth-first from first_vertex; each walk
//   returns the start vertex, then every newly visited vertex in visit order
//   on out_ch, with last set on the final one. Visited marks persist across
//   walks. Requests naming a vertex at or above vertex_count, and cmd 3, are
//   taken and dropped. vertex_count is written over the APB port (address 0).
// Timing
//   One request at a time; in_ch.ready is high only between requests. Adding
//   an edge is a read-modify-write of two rows through the one adjacency RAM.
//   Each report leaves once the walk finds the next vertex, or at its end. A
//   breadth-first walk dequeues a vertex, reads its row and reports its
//   unvisited neighbors lowest first; a depth-first walk reads the top row,
//   reports and pushes its lowest unvisited neighbor, or pops on a backtrack
//   (shared priority encoder, registered RAM read).
// Reset and stall
//   Reset empties the graph and visited marks at once through per-row valid
//   bits and sets vertex_count to 32. A result waits in the output register;
//   while the receiver stalls, the walk holds at its next report.
module graph_bfs_dfs_traversal import gbt_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gbt_in_if.sink            in_ch,
  gbt_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int VW = $clog2(MAX_VERTICES);       // vertex index width
  localparam int PW = $clog2(MAX_VERTICES + 1);   // queue/stack pointer width
  localparam int NW = (PW > VC_W) ? PW : VC_W;    // vertex count compare width

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WA,
    S_ADD_RB,
    S_ADD_WB,
    S_B_POP,
    S_B_QRD,
    S_B_ROW,
    S_B_SCAN,
    S_D_TOP,
    S_D_CAND,
    S_D_POP,
    S_FIN
  } state_t;

  // Control state
  state_t              state_r, state_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] row_vld_r, row_vld_nxt;
  logic [VC_W-1:0]     vertex_count_r, vertex_count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [PW-1:0]       head_r, head_nxt;
  logic [PW-1:0]       tail_r, tail_nxt;
  logic [PW-1:0]       sp_r, sp_nxt;

  // Payload
  logic [VTX_W-1:0]        out_vertex_r, out_vertex_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [VW-1:0]           pend_v_r, pend_v_nxt;
  logic [VW-1:0]           a_r, a_nxt;
  logic [VW-1:0]           b_r, b_nxt;
  logic [VW-1:0]           top_r, top_nxt;
  logic [VW-1:0]           rd_row_r, rd_row_nxt;
  logic [MAX_VERTICES-1:0] cand_r, cand_nxt;

  // RAM ports
  logic                    adj_we, adj_re;
  logic [VW-1:0]           adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    qs_we, qs_re;
  logic [VW-1:0]           qs_waddr, qs_raddr, qs_wdata, qs_rdata;

  // Datapath
  logic [NW-1:0]           n_eff;
  logic [MAX_VERTICES-1:0] vmask;
  logic [MAX_VERTICES-1:0] row_q;
  logic [MAX_VERTICES-1:0] cand_d;
  logic [MAX_VERTICES-1:0] enc_in;
  logic [VW-1:0]           enc_idx;
  logic [MAX_VERTICES-1:0] bit_u;
  logic                    out_free;
  logic                    in_fire;
  logic                    a_ok, b_ok;
  logic [VW-1:0]           a_idx, b_idx;
  logic                    cfg_wr;

  // Adjacency rows, one word per vertex
  gbt_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // Breadth-first queue and depth-first stack share one store; a walk uses
  // only one of them.
  gbt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_qs_ram (
    .clk   (clk),
    .we    (qs_we),
    .waddr (qs_waddr),
    .wdata (qs_wdata),
    .re    (qs_re),
    .raddr (qs_raddr),
    .rdata (qs_rdata)
  );

  // Effective vertex count saturates at the graph size; vertices at or above it are
  // masked out of every candidate set.
  always_comb begin
    n_eff = (NW'(vertex_count_r) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                      : NW'(vertex_count_r);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      vmask[i] = (NW'(i) < n_eff);
    end
  end

  assign a_ok  = NW'(in_ch.first_vertex) < n_eff;
  assign b_ok  = NW'(in_ch.second_vertex) < n_eff;
  assign a_idx = VW'(in_ch.first_vertex);
  assign b_idx = VW'(in_ch.second_vertex);

  // A row never written reads as empty.
  assign row_q  = row_vld_r[rd_row_r] ? adj_rdata : '0;
  assign cand_d = row_q & vmask & ~visited_r;

  // Shared lowest-set-bit encoder: the depth-first walk feeds it straight
  // from the row read, the breadth-first walk from the held candidate set.
  always_comb begin
    enc_in  = (state_r == S_D_CAND) ? cand_d : cand_r;
    enc_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (enc_in[i]) begin
        enc_idx = VW'(i);
      end
    end
    bit_u          = '0;
    bit_u[enc_idx] = 1'b1;
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && (state_r == S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && (paddr[APB_AW-1] == REG_VERTEX_COUNT);

  always_comb begin
    state_nxt        = state_r;
    visited_nxt      = visited_r;
    row_vld_nxt      = row_vld_r;
    vertex_count_nxt = vertex_count_r;
    out_valid_nxt    = out_valid_r;
    pend_valid_nxt   = pend_valid_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    sp_nxt           = sp_r;
    out_vertex_nxt   = out_vertex_r;
    out_last_nxt     = out_last_r;
    pend_v_nxt       = pend_v_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    top_nxt          = top_r;
    rd_row_nxt       = rd_row_r;
    cand_nxt         = cand_r;

    adj_we    = 1'b0;
    adj_waddr = a_r;
    adj_wdata = '0;
    adj_re    = 1'b0;
    adj_raddr = a_r;
    qs_we     = 1'b0;
    qs_waddr  = '0;
    qs_wdata  = '0;
    qs_re     = 1'b0;
    qs_raddr  = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      vertex_count_nxt = pwdata[VC_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && a_ok) begin
          if (in_ch.cmd == CMD_ADD) begin
            if (b_ok) begin
              a_nxt      = a_idx;
              b_nxt      = b_idx;
              adj_re     = 1'b1;
              adj_raddr  = a_idx;
              rd_row_nxt = a_idx;
              state_nxt  = S_ADD_WA;
            end
          end else if (in_ch.cmd == CMD_BFS || in_ch.cmd == CMD_DFS) begin
            // Start vertex is reported first even if already visited.
            visited_nxt[a_idx] = 1'b1;
            pend_v_nxt         = a_idx;
            pend_valid_nxt     = 1'b1;
            qs_we              = 1'b1;
            qs_waddr           = '0;
            qs_wdata           = a_idx;
            if (in_ch.cmd == CMD_BFS) begin
              head_nxt  = '0;
              tail_nxt  = PW'(1);
              state_nxt = S_B_POP;
            end else begin
              sp_nxt    = PW'(1);
              top_nxt   = a_idx;
              state_nxt = S_D_TOP;
            end
          end
        end
      end

      S_ADD_WA: begin
        adj_we           = 1'b1;
        adj_waddr        = a_r;
        adj_wdata        = row_q | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_r);
        row_vld_nxt[a_r] = 1'b1;
        state_nxt        = S_ADD_RB;
      end

      S_ADD_RB: begin
        adj_re     = 1'b1;
        adj_raddr  = b_r;
        rd_row_nxt = b_r;
        state_nxt  = S_ADD_WB;
      end

      S_ADD_WB: begin
        adj_we           = 1'b1;
        adj_waddr        = b_r;
        adj_wdata        = row_q | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_r);
        row_vld_nxt[b_r] = 1'b1;
        state_nxt        = S_IDLE;
      end

      S_B_POP: begin
        if (head_r == tail_r) begin
          state_nxt = S_FIN;
        end else begin
          qs_re     = 1'b1;
          qs_raddr  = VW'(head_r);
          head_nxt  = head_r + PW'(1);
          state_nxt = S_B_QRD;
        end
      end

      S_B_QRD: begin
        adj_re     = 1'b1;
        adj_raddr  = qs_rdata;
        rd_row_nxt = qs_rdata;
        state_nxt  = S_B_ROW;
      end

      S_B_ROW: begin
        cand_nxt  = cand_d;
        state_nxt = S_B_SCAN;
      end

      S_B_SCAN: begin
        if (cand_r == '0) begin
          state_nxt = S_B_POP;
        end else if (out_free) begin
          // Release the held report and keep the new vertex back until the
          // next one shows whether it ends the walk.
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = VTX_W'(pend_v_r);
          out_last_nxt   = 1'b0;
          pend_v_nxt     = enc_idx;
          visited_nxt    = visited_r | bit_u;
          cand_nxt       = cand_r & ~bit_u;
          qs_we          = 1'b1;
          qs_waddr       = VW'(tail_r);
          qs_wdata       = enc_idx;
          tail_nxt       = tail_r + PW'(1);
        end
      end

      S_D_TOP: begin
        adj_re     = 1'b1;
        adj_raddr  = top_r;
        rd_row_nxt = top_r;
        state_nxt  = S_D_CAND;
      end

      S_D_CAND: begin
        // Lower neighbors were visited when tried, so the unvisited set alone
        // gives the next one to try.
        if (cand_d == '0) begin
          sp_nxt = sp_r - PW'(1);
          if (sp_r == PW'(1)) begin
            state_nxt = S_FIN;
          end else begin
            qs_re     = 1'b1;
            qs_raddr  = VW'(sp_r - PW'(2));
            state_nxt = S_D_POP;
          end
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = VTX_W'(pend_v_r);
          out_last_nxt   = 1'b0;
          pend_v_nxt     = enc_idx;
          visited_nxt    = visited_r | bit_u;
          qs_we          = 1'b1;
          qs_waddr       = VW'(sp_r);
          qs_wdata       = enc_idx;
          sp_nxt         = sp_r + PW'(1);
          top_nxt        = enc_idx;
          state_nxt      = S_D_TOP;
        end
      end

      S_D_POP: begin
        top_nxt   = qs_rdata;
        state_nxt = S_D_TOP;
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = VTX_W'(pend_v_r);
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          head_nxt       = '0;
          tail_nxt       = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_vertex_r <= out_vertex_nxt;
    out_last_r   <= out_last_nxt;
    pend_v_r     <= pend_v_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    top_r        <= top_nxt;
    rd_row_r     <= rd_row_nxt;
    cand_r       <= cand_nxt;
    if (!rst_n) begin
      state_r        <= S_IDLE;
      visited_r      <= '0;
      row_vld_r      <= '0;
      vertex_count_r <= VC_RESET;
      out_valid_r    <= 1'b0;
      pend_valid_r   <= 1'b0;
      head_r         <= '0;
      tail_r         <= '0;
      sp_r           <= '0;
    end else begin
      state_r        <= state_nxt;
      visited_r      <= visited_nxt;
      row_vld_r      <= row_vld_nxt;
      vertex_count_r <= vertex_count_nxt;
      out_valid_r    <= out_valid_nxt;
      pend_valid_r   <= pend_valid_nxt;
      head_r         <= head_nxt;
      tail_r         <= tail_nxt;
      sp_r           <= sp_nxt;
    end
  end

  // Ports
  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.visited_vertex = out_vertex_r;
  assign out_ch.last           = out_last_r;
  assign pready                = 1'b1;
  assign prdata = (paddr[APB_AW-1] == REG_VERTEX_COUNT) ? APB_DW'(vertex_count_r) : '0;

  // Checks
  a_visited_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ((visited_r & $past(visited_r)) == $past(visited_r)))
    else $error("visited mark cleared outside reset");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("held report left behind at end of walk");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r <= PW'(MAX_VERTICES)) && (sp_r <= PW'(MAX_VERTICES)))
    else $error("queue or stack beyond graph size");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && out_last_r))
    else $error("walk ended without a final report");

endmodule

>>> tb/graph_bfs_dfs_traversal_tb.sv
// Self-checking testbench for the graph traversal block: directed and random requests.
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_tb;
  import gbt_pkg::*;

  localparam int                NUM_V        = MAX_VERTICES_DEF;
  // cmd 3 has no meaning; the block takes it and drops it
  localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
  // slack after the last report before the block counts as idle
  localparam int                DRAIN_CYCLES = 40;
  localparam logic [APB_AW-1:0] VC_ADDR      = {REG_VERTEX_COUNT, 2'b00};

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
  } visit_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  gbt_in_if  req_if ();
  gbt_out_if rsp_if ();

  graph_bfs_dfs_traversal dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_if),
    .out_ch  (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the graph: adjacency rows, visited marks and the vertex count.
  logic [NUM_V-1:0] adj_rows [NUM_V];
  logic [NUM_V-1:0] visited_set;
  logic [VC_W-1:0]  vertex_count_q;

  // Reports still owed by the block, oldest first.
  visit_t expected_visits [$];

  int error_count;
  bit idle_en;        // random bursts of idling on both channels
  int hold_off_left;  // long receiver hold-off, counted down by the receiver process
  int stall_left;     // remaining cycles of the current receiver burst

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Vertex count as the block applies it: saturated to the graph size.
  function automatic int active_vertices();
    return (vertex_count_q > NUM_V) ? NUM_V : int'(vertex_count_q);
  endfunction

  // Apply one accepted request to the local graph and queue the reports it causes.
  function automatic void walk_graph(input logic [CMD_W-1:0] cmd,
                                     input logic [VTX_W-1:0] a,
                                     input logic [VTX_W-1:0] b);
    int               n;
    int               v;
    int               u;
    int               top;
    int               depth;
    int               frontier [$];
    int               stk_vertex [NUM_V];
    int               stk_next [NUM_V];
    logic [NUM_V-1:0] in_use;
    logic [NUM_V-1:0] cand;
    visit_t           walk [$];

    n = active_vertices();
    // A start or endpoint outside the active range drops the request.
    if (int'(a) >= n) return;
    in_use = {NUM_V{1'b1}} >> (NUM_V - n);

    case (cmd)
      CMD_ADD: begin
        if (int'(b) >= n) return;
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
        return;
      end
      CMD_BFS: begin
        // The start is reported even when it was visited by an earlier walk.
        visited_set[a] = 1'b1;
        walk.push_back('{a, 1'b0});
        frontier.push_back(int'(a));
        while (frontier.size() > 0) begin
          v    = frontier.pop_front();
          // Neighbors beyond the active range are never followed.
          cand = adj_rows[v] & in_use & ~visited_set;
          for (u = 0; u < NUM_V; u++) begin
            if (cand[u]) begin
              visited_set[u] = 1'b1;
              frontier.push_back(u);
              walk.push_back('{VTX_W'(u), 1'b0});
            end
          end
        end
      end
      CMD_DFS: begin
        visited_set[a] = 1'b1;
        walk.push_back('{a, 1'b0});
        stk_vertex[0] = int'(a);
        stk_next[0]   = 0;
        depth         = 1;
        while (depth > 0) begin
          top  = depth - 1;
          cand = adj_rows[stk_vertex[top]] & in_use & ~visited_set;
          // Resume the scan of this frame's row after the neighbor tried last.
          u    = stk_next[top];
          while (u < NUM_V && !cand[u]) u++;
          if (u >= NUM_V) begin
            depth--;
          end else begin
            stk_next[top]  = u + 1;
            visited_set[u] = 1'b1;
            walk.push_back('{VTX_W'(u), 1'b0});
            if (depth < NUM_V) begin
              stk_vertex[depth] = u;
              stk_next[depth]   = 0;
              depth++;
            end
          end
        end
      end
      default: return;
    endcase

    walk[walk.size() - 1].last = 1'b1;
    foreach (walk[i]) expected_visits.push_back(walk[i]);
  endfunction

  // Receiver: a long hold-off wins over random bursts; no new bursts start when idling is off.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      rsp_if.ready = 1'b0;
      hold_off_left--;
    end else if (stall_left > 0) begin
      rsp_if.ready = 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rsp_if.ready = 1'b0;
      stall_left   = $urandom_range(0, 9);
    end else begin
      rsp_if.ready = 1'b1;
    end
  end

  // Compare every accepted report with the oldest one still owed.
  always @(posedge clk) begin
    visit_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_visits.size() == 0) begin
        $error("unexpected report: visited_vertex=%0d last=%0b",
               rsp_if.visited_vertex, rsp_if.last);
        error_count++;
      end else begin
        want = expected_visits.pop_front();
        if (rsp_if.visited_vertex !== want.vertex) begin
          $error("visited_vertex: expected %0d, got %0d", want.vertex, rsp_if.visited_vertex);
          error_count++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, rsp_if.last);
          error_count++;
        end
      end
    end
  end

  // Offer one request, optionally after a random gap, and hold it until taken.
  // Valid stays high after the handshake so that the next request follows without a bubble.
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [VTX_W-1:0] a,
                              input logic [VTX_W-1:0] b);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid         = 1'b1;
    req_if.cmd           = cmd;
    req_if.first_vertex  = a;
    req_if.second_vertex = b;
    do @(posedge clk); while (!req_if.ready);
    walk_graph(cmd, a, b);
  endtask

  // Drop valid, wait for every owed report, then let the block finish any silent request.
  task automatic settle_idle();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_visits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic read_vertex_count(output logic [APB_DW-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = VC_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Register writes only happen with the block idle; each write is read back.
  task automatic write_vertex_count(input logic [VC_W-1:0] value);
    logic [APB_DW-1:0] readback;
    settle_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = VC_ADDR;
    pwdata  = APB_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    vertex_count_q = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    read_vertex_count(readback);
    if (readback[VC_W-1:0] !== value) begin
      $error("vertex_count: expected %0d, got %0d", value, readback[VC_W-1:0]);
      error_count++;
    end
  endtask

  // Random requests; count only those the block acts on. A small share is noise:
  // vertices anywhere in the field range and the unused command.
  task automatic send_random_requests(input int count, input int edge_pct);
    int               useful;
    int               n;
    int               r;
    bit               noise;
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    useful = 0;
    while (useful < count) begin
      n     = active_vertices();
      noise = ($urandom_range(0, 99) < 8);
      r     = $urandom_range(0, 99);
      if (r < edge_pct) cmd = CMD_ADD;
      else if (r[0])    cmd = CMD_BFS;
      else              cmd = CMD_DFS;
      a = noise ? VTX_W'($urandom_range(0, NUM_V - 1)) : VTX_W'($urandom_range(0, n - 1));
      b = noise ? VTX_W'($urandom_range(0, NUM_V - 1)) : VTX_W'($urandom_range(0, n - 1));
      if (noise && $urandom_range(0, 3) == 0) cmd = CMD_UNUSED;
      if (cmd != CMD_UNUSED && int'(a) < n && (cmd != CMD_ADD || int'(b) < n)) useful++;
      send_request(cmd, a, b);
    end
  endtask

  task automatic test_reset_value();
    logic [APB_DW-1:0] value;
    read_vertex_count(value);
    if (value[VC_W-1:0] !== VC_RESET) begin
      $error("vertex_count: expected %0d, got %0d", VC_RESET, value[VC_W-1:0]);
      error_count++;
    end
  endtask

  // Small graph at both ends of the vertex range: fan-out for breadth-first,
  // a branch with backtracking and a self loop for depth-first.
  task automatic test_directed_walks();
    send_request(CMD_ADD, 5'd0, 5'd1);
    send_request(CMD_ADD, 5'd0, 5'd2);
    send_request(CMD_ADD, 5'd1, 5'd3);
    send_request(CMD_ADD, 5'd2, 5'd3);
    send_request(CMD_ADD, 5'd31, 5'd30);
    send_request(CMD_ADD, 5'd30, 5'd29);
    send_request(CMD_ADD, 5'd31, 5'd28);
    send_request(CMD_ADD, 5'd31, 5'd31);      // self loop, never reported twice
    send_request(CMD_UNUSED, 5'd31, 5'd31);
    send_request(CMD_BFS, 5'd0, 5'd31);
    send_request(CMD_DFS, 5'd31, 5'd0);
    send_request(CMD_DFS, 5'd0, 5'd0);        // start already visited
    send_request(CMD_BFS, 5'd3, 5'd0);
  endtask

  // Zero, saturated and shrunk vertex counts.
  task automatic test_vertex_count_limits();
    write_vertex_count(6'd0);                 // every request dropped
    send_request(CMD_BFS, 5'd4, 5'd0);
    send_request(CMD_ADD, 5'd0, 5'd0);
    send_request(CMD_DFS, 5'd0, 5'd0);
    write_vertex_count(6'd63);                // saturates to the graph size
    send_request(CMD_ADD, 5'd10, 5'd11);
    send_request(CMD_ADD, 5'd10, 5'd12);
    send_request(CMD_ADD, 5'd5, 5'd6);
    send_request(CMD_BFS, 5'd5, 5'd0);
    write_vertex_count(6'd11);                // edges to 11 and 12 are out of reach
    send_request(CMD_BFS, 5'd10, 5'd0);
    send_request(CMD_ADD, 5'd4, 5'd20);
    send_request(CMD_DFS, 5'd20, 5'd0);
    write_vertex_count(6'd1);
    send_request(CMD_BFS, 5'd0, 5'd0);
    send_request(CMD_DFS, 5'd1, 5'd0);
  endtask

  // Change the active range phase by phase, mostly widening it, so that later phases find fresh vertices.
  // Each phase is edge-heavy first, then mixes in more walks.
  task automatic test_random_traffic();
    logic [VC_W-1:0] counts [5];
    counts = '{6'd12, 6'd20, VC_W'($urandom_range(1, NUM_V)), 6'd32, 6'd45};
    foreach (counts[i]) begin
      write_vertex_count(counts[i]);
      send_random_requests(14, 80);
      send_random_requests(14, 35);
    end
  endtask

  // Hold the receiver off while requests keep coming, so the block backs up to its input.
  task automatic test_output_backpressure();
    @(posedge clk);
    hold_off_left = 300;
    send_random_requests(16, 30);
  endtask

  // Pause the sender until the block has drained, then resume.
  task automatic test_drain_and_resume();
    settle_idle();
    send_random_requests(8, 30);
  endtask

  // Final stretch with no idling on either side.
  task automatic test_back_to_back();
    idle_en = 1'b0;
    send_random_requests(20, 30);
    settle_idle();
  endtask

  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_if.valid         = 1'b0;
    req_if.cmd           = CMD_ADD;
    req_if.first_vertex  = '0;
    req_if.second_vertex = '0;
    rsp_if.ready         = 1'b0;
    error_count          = 0;
    idle_en              = 1'b1;
    hold_off_left        = 0;
    stall_left           = 0;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    visited_set          = '0;
    vertex_count_q       = VC_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_value();
    test_directed_walks();
    test_vertex_count_limits();
    test_random_traffic();
    test_output_backpressure();
    test_drain_and_resume();
    test_back_to_back();

    if (error_count == 0) begin
      $display("graph_bfs_dfs_traversal_tb: PASS");
    end else begin
      $display("graph_bfs_dfs_traversal_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("graph_bfs_dfs_traversal_tb: FAIL");
    $finish;
  end

endmodule
